// File: sv/csched_pkg.sv
package csched_pkg;

   // slot phase codes
   typedef enum logic [1:0] {
      PH_FADE_IN  = 2'd0,
      PH_HOLD     = 2'd1,
      PH_WAIT     = 2'd2,
      PH_FADE_OUT = 2'd3
   } phase_type;

   // request codes (code 3 is unknown and only acknowledged)
   localparam logic [1:0] RQ_TICK     = 2'd0;
   localparam logic [1:0] RQ_START    = 2'd1;
   localparam logic [1:0] RQ_FADE_ALL = 2'd2;
   localparam logic [1:0] RQ_UNUSED   = 2'd3;

   // register indexes
   localparam logic CSR_FADE_TICKS = 1'b0;
   localparam logic CSR_MIN_SHOW   = 1'b1;

   localparam logic [15:0] FADE_TICKS_RST = 16'd1024;
   localparam logic [23:0] MIN_SHOW_RST   = 24'd8192;
   localparam logic [15:0] ONE_Q15        = 16'h8000;
   localparam logic [15:0] FADE_MAX       = 16'hFFFF;
   localparam logic [23:0] HOLD_MAX       = 24'hFFFFFF;
   localparam logic [3:0]  DIV_STEPS      = 4'd15;

   // one table entry
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  tag;
      logic [15:0] fade_elapsed;
      logic [23:0] hold_elapsed;
      logic [15:0] fade_peak;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clr_ptr;
      logic append;
      logic rd;
      logic compact;
      logic pass_end;
      logic load_rep;
      logic load_all;
      logic div_start;
      logic mix;
      logic emit_slot;
      logic emit_ack;
      logic ack_full;
      logic wr_all;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_kind;
      logic       count_zero;
      logic       full;
      logic       last_rd;
      logic       frac_need;
      phase_type  cur_phase;
      logic       div_done;
      logic       out_free;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ACK,
      S_ACK_FULL,
      S_T_RD,
      S_T_UPD,
      S_T_END,
      S_T_CHK,
      S_R_RD,
      S_R_UPD,
      S_R_CHK,
      S_R_DIV,
      S_R_MUL,
      S_R_OUT,
      S_F_RD,
      S_F_UPD,
      S_F_CHK,
      S_F_DIV,
      S_F_WR
   } state_type;

endpackage

// File: sv/csched_if.sv
// request channel
interface csched_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] dt_ticks;
   logic [7:0]  layer_tag;
   modport source (output valid, output req_type, output dt_ticks, output layer_tag,
                   input ready);
   modport sink   (input valid, input req_type, input dt_ticks, input layer_tag,
                   output ready);
endinterface

// result channel
interface csched_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  slot_index;
   logic        slot_valid;
   logic [7:0]  layer_tag_out;
   logic [1:0]  phase;
   logic [15:0] mix_coeff;
   logic        status;
   logic        last;
   modport source (output valid, output slot_index, output slot_valid,
                   output layer_tag_out, output phase, output mix_coeff,
                   output status, output last, input ready);
   modport sink   (input valid, input slot_index, input slot_valid,
                   input layer_tag_out, input phase, input mix_coeff,
                   input status, input last, output ready);
endinterface

// register write channel
interface csched_csr_if;
   logic        valid;
   logic        ready;
   logic        addr;
   logic [23:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: sv/csched_div.sv
// restoring divider: quot = floor(num * 2^15 / den), valid for num < den
module csched_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] num,
   input  logic [15:0] den,
   output logic [15:0] quot,
   output logic        done,
   output logic        busy
);
   import csched_pkg::*;

   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff;
   logic [14:0] quot_ff;
   logic [3:0]  step_ff;
   logic        busy_ff, done_ff;
   logic [16:0] shifted, diff;
   logic        ge;

   // one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = ge ? diff[15:0] : shifted[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         quot_ff <= '0;
         step_ff <= DIV_STEPS;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[13:0], ge};
         step_ff <= step_ff - 4'd1;
         if (step_ff == 4'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quot = {1'b0, quot_ff};
   assign done = done_ff;
   assign busy = busy_ff;

endmodule

// File: sv/csched_dp.sv
module csched_dp #(
   parameter int SLOTS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  csched_pkg::dp_cmd_type  cmd,
   output csched_pkg::dp_stat_type stat,
   input  logic [1:0]              req_type,
   input  logic [15:0]             dt_ticks,
   input  logic [7:0]              layer_tag,
   input  logic                    csr_valid,
   input  logic                    csr_addr,
   input  logic [23:0]             csr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              slot_index,
   output logic                    slot_valid,
   output logic [7:0]              layer_tag_out,
   output logic [1:0]              phase,
   output logic [15:0]             mix_coeff,
   output logic                    status,
   output logic                    last
);
   import csched_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

   logic [15:0]      fade_ticks_ff;
   logic [23:0]      min_show_ff;
   logic [1:0]       req_kind_ff;
   logic [15:0]      dt_ff;
   logic [7:0]       tag_ff;
   logic [CNT_W-1:0] count_ff, rptr_ff, wptr_ff, rnext;
   logic             any_in_ff, seen_wait_ff;
   entry_type        mem [SLOTS];
   entry_type        rd_data_ff, cur_ff;
   logic [15:0]      mix_ff;

   logic             rsp_valid_ff, slot_valid_ff, status_ff, last_ff;
   logic [2:0]       slot_index_ff;
   logic [7:0]       tag_out_ff;
   logic [1:0]       phase_ff;
   logic [15:0]      mix_out_ff;

   logic [16:0]      two_fade;
   logic [23:0]      two_ext, hold_len;
   logic [16:0]      fe_sum;
   logic [24:0]      he_sum;
   logic [15:0]      fe_sat;
   logic [23:0]      he_sat;
   entry_type        upd, rep, fo, wr_data;
   logic             gone, trig, is_wait;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0]      div_q, frac, inv;
   logic             div_done, div_busy, frac_need;
   logic [31:0]      prod;
   logic [15:0]      mix_in;
   logic             out_free;

   csched_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (cur_ff.fade_elapsed),
      .den   (fade_ticks_ff),
      .quot  (div_q),
      .done  (div_done),
      .busy  (div_busy)
   );

   // hold length, floored at zero
   always_comb begin
      two_fade = {fade_ticks_ff, 1'b0};
      two_ext  = 24'(two_fade);
      hold_len = (min_show_ff > two_ext) ? (min_show_ff - two_ext) : '0;
   end

   // timer advance of the entry just read
   always_comb begin
      fe_sum = {1'b0, rd_data_ff.fade_elapsed} + {1'b0, dt_ff};
      he_sum = {1'b0, rd_data_ff.hold_elapsed} + {9'd0, dt_ff};
      fe_sat = fe_sum[16] ? FADE_MAX : fe_sum[15:0];
      he_sat = he_sum[24] ? HOLD_MAX : he_sum[23:0];
      upd    = rd_data_ff;
      gone   = 1'b0;
      unique case (rd_data_ff.phase)
         PH_FADE_IN: begin
            upd.fade_elapsed = fe_sat;
            if (fe_sat >= fade_ticks_ff) begin
               upd.phase        = PH_HOLD;
               upd.hold_elapsed = '0;
            end
         end
         PH_HOLD: begin
            upd.hold_elapsed = he_sat;
            if (he_sat >= hold_len) upd.phase = PH_WAIT;
         end
         PH_WAIT: begin
         end
         PH_FADE_OUT: begin
            upd.fade_elapsed = fe_sat;
            gone             = fe_sat >= fade_ticks_ff;
         end
      endcase
   end

   // report pass trigger: the oldest waiting slot is spared when nothing is in
   always_comb begin
      is_wait = rd_data_ff.phase == PH_WAIT;
      trig    = is_wait && (any_in_ff || seen_wait_ff);
      rep     = rd_data_ff;
      if (trig) begin
         rep.phase        = PH_FADE_OUT;
         rep.fade_elapsed = '0;
      end
   end

   // fraction and fade-out-all entry
   always_comb begin
      frac_need = cur_ff.fade_elapsed < fade_ticks_ff;
      frac      = frac_need ? div_q : ONE_Q15;
      fo        = cur_ff;
      fo.phase        = PH_FADE_OUT;
      fo.fade_elapsed = '0;
      if (cur_ff.phase == PH_FADE_IN) fo.fade_peak = frac;
   end

   // mix coefficient
   always_comb begin
      inv  = ONE_Q15 - frac;
      prod = {16'd0, inv} * {16'd0, cur_ff.fade_peak};
      unique case (cur_ff.phase)
         PH_FADE_IN:       mix_in = frac;
         PH_HOLD, PH_WAIT: mix_in = cur_ff.fade_peak;
         PH_FADE_OUT:      mix_in = prod[30:15];
      endcase
   end

   // single write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rptr_ff[IDX_W-1:0];
      wr_data = fo;
      priority if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = '{phase: PH_FADE_IN, tag: tag_ff, fade_elapsed: '0,
                     hold_elapsed: '0, fade_peak: ONE_Q15};
      end else if (cmd.compact) begin
         wr_en   = !gone;
         wr_addr = wptr_ff[IDX_W-1:0];
         wr_data = upd;
      end else if (cmd.load_rep) begin
         wr_en   = 1'b1;
         wr_data = rep;
      end else if (cmd.wr_all) begin
         wr_en   = 1'b1;
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd) rd_data_ff <= mem[rptr_ff[IDX_W-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ticks_ff <= FADE_TICKS_RST;
         min_show_ff   <= MIN_SHOW_RST;
      end else if (csr_valid) begin
         if (csr_addr == CSR_FADE_TICKS) fade_ticks_ff <= csr_data[15:0];
         else                            min_show_ff   <= csr_data;
      end
   end

   // request latch, pointers and working registers
   assign rnext = rptr_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         any_in_ff    <= 1'b0;
         seen_wait_ff <= 1'b0;
      end else begin
         if (cmd.clr_ptr) begin
            rptr_ff      <= '0;
            wptr_ff      <= '0;
            any_in_ff    <= 1'b0;
            seen_wait_ff <= 1'b0;
         end
         if (cmd.append) count_ff <= count_ff + CNT_W'(1);
         if (cmd.compact) begin
            rptr_ff <= rnext;
            if (!gone) begin
               wptr_ff <= wptr_ff + CNT_W'(1);
               if (upd.phase == PH_FADE_IN || upd.phase == PH_HOLD) any_in_ff <= 1'b1;
            end
         end
         if (cmd.pass_end) begin
            count_ff     <= wptr_ff;
            rptr_ff      <= '0;
            seen_wait_ff <= 1'b0;
         end
         if (cmd.load_rep && is_wait) seen_wait_ff <= 1'b1;
         if (cmd.emit_slot || cmd.wr_all) rptr_ff <= rnext;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_kind_ff <= req_type;
         dt_ff       <= dt_ticks;
         tag_ff      <= layer_tag;
      end
      if (cmd.load_rep) cur_ff <= rep;
      if (cmd.load_all) cur_ff <= rd_data_ff;
      if (cmd.mix) mix_ff <= mix_in;
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_slot || cmd.emit_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_slot) begin
         slot_index_ff <= 3'(rptr_ff);
         slot_valid_ff <= 1'b1;
         tag_out_ff    <= cur_ff.tag;
         phase_ff      <= cur_ff.phase;
         mix_out_ff    <= mix_ff;
         status_ff     <= 1'b0;
         last_ff       <= rnext == count_ff;
      end else if (cmd.emit_ack) begin
         slot_index_ff <= '0;
         slot_valid_ff <= 1'b0;
         tag_out_ff    <= '0;
         phase_ff      <= '0;
         mix_out_ff    <= '0;
         status_ff     <= cmd.ack_full;
         last_ff       <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign slot_index    = slot_index_ff;
   assign slot_valid    = slot_valid_ff;
   assign layer_tag_out = tag_out_ff;
   assign phase         = phase_ff;
   assign mix_coeff     = mix_out_ff;
   assign status        = status_ff;
   assign last          = last_ff;

   // status to controller
   always_comb begin
      stat.req_kind   = req_kind_ff;
      stat.count_zero = count_ff == '0;
      stat.full       = count_ff >= SLOTS_C;
      stat.last_rd    = rnext == count_ff;
      stat.frac_need  = frac_need;
      stat.cur_phase  = cur_ff.phase;
      stat.div_done   = div_done;
      stat.out_free   = out_free;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_C)
      else $error("slot count beyond table size");
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> count_ff < SLOTS_C)
      else $error("append into a full table");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_slot || cmd.emit_ack) |-> out_free)
      else $error("result overwrites a pending transaction");
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      cmd.compact |-> wptr_ff <= rptr_ff)
      else $error("compaction write ahead of read");

endmodule

// File: sv/csched_ctrl.sv
module csched_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  csched_pkg::dp_stat_type stat,
   output csched_pkg::dp_cmd_type  cmd
);
   import csched_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.clr_ptr = 1'b1;
            priority case (stat.req_kind)
               RQ_TICK:     state_in = stat.count_zero ? S_ACK : S_T_RD;
               RQ_START: begin
                  if (stat.full) begin
                     state_in = S_ACK_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     state_in   = S_ACK;
                  end
               end
               RQ_FADE_ALL: state_in = stat.count_zero ? S_ACK : S_F_RD;
               default:     state_in = S_ACK;
            endcase
         end
         S_ACK: begin
            if (stat.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ACK_FULL: begin
            if (stat.out_free) begin
               cmd.emit_ack = 1'b1;
               cmd.ack_full = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // advance and compact
         S_T_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_T_UPD;
         end
         S_T_UPD: begin
            cmd.compact = 1'b1;
            state_in    = stat.last_rd ? S_T_END : S_T_RD;
         end
         S_T_END: begin
            cmd.pass_end = 1'b1;
            state_in     = S_T_CHK;
         end
         S_T_CHK: state_in = stat.count_zero ? S_ACK : S_R_RD;
         // trigger waiting slots and report
         S_R_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_R_UPD;
         end
         S_R_UPD: begin
            cmd.load_rep = 1'b1;
            state_in     = S_R_CHK;
         end
         S_R_CHK: begin
            if (stat.frac_need &&
                (stat.cur_phase == PH_FADE_IN || stat.cur_phase == PH_FADE_OUT)) begin
               cmd.div_start = 1'b1;
               state_in      = S_R_DIV;
            end else begin
               state_in = S_R_MUL;
            end
         end
         S_R_DIV: if (stat.div_done) state_in = S_R_MUL;
         S_R_MUL: begin
            cmd.mix  = 1'b1;
            state_in = S_R_OUT;
         end
         S_R_OUT: begin
            if (stat.out_free) begin
               cmd.emit_slot = 1'b1;
               state_in      = stat.last_rd ? S_IDLE : S_R_RD;
            end
         end
         // fade out every slot
         S_F_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_F_UPD;
         end
         S_F_UPD: begin
            cmd.load_all = 1'b1;
            state_in     = S_F_CHK;
         end
         S_F_CHK: begin
            if (stat.frac_need && stat.cur_phase == PH_FADE_IN) begin
               cmd.div_start = 1'b1;
               state_in      = S_F_DIV;
            end else begin
               state_in = S_F_WR;
            end
         end
         S_F_DIV: if (stat.div_done) state_in = S_F_WR;
         S_F_WR: begin
            cmd.wr_all = 1'b1;
            state_in   = stat.last_rd ? S_ACK : S_F_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: sv/crossfade_slot_scheduler.sv
// channel   role     handshake          payload
// req_chan  sink     valid/ready        req_type, dt_ticks, layer_tag
// rsp_chan  source   valid/ready        slot_index, slot_valid, layer_tag_out,
//                                       phase, mix_coeff, status, last
// csr_chan  sink     valid (ready=1)    addr (0 fade_ticks, 1 min_show_ticks), data
//
// One transaction at a time. Start and unknown requests, and a tick or
// fade-out-all on an empty table, are acknowledged without a table walk. A
// fade-out-all walks every slot once. A tick walks the table once for
// compaction and then once more to report each remaining slot. A slot whose
// fade fraction is needed goes through the shared 15-step divider.
// Synchronous reset empties the table and restores the registers. A stalled
// result holds the controller at its emit step; the next request is taken
// once the controller is back at idle.
module crossfade_slot_scheduler #(
   parameter int SLOTS = 8
) (
   input logic         clock,
   input logic         reset,
   csched_req_if.sink   req_chan,
   csched_rsp_if.source rsp_chan,
   csched_csr_if.sink   csr_chan
);
   import csched_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   csched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csched_dp #(.SLOTS(SLOTS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_chan.req_type),
      .dt_ticks      (req_chan.dt_ticks),
      .layer_tag     (req_chan.layer_tag),
      .csr_valid     (csr_chan.valid),
      .csr_addr      (csr_chan.addr),
      .csr_data      (csr_chan.data),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .slot_index    (rsp_chan.slot_index),
      .slot_valid    (rsp_chan.slot_valid),
      .layer_tag_out (rsp_chan.layer_tag_out),
      .phase         (rsp_chan.phase),
      .mix_coeff     (rsp_chan.mix_coeff),
      .status        (rsp_chan.status),
      .last          (rsp_chan.last)
   );

endmodule
